FILE: sv/midi_note_sine_oscillator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MIDI note sine oscillator checker
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_SINE_OSCILLATOR_TOP_ASSERT_SVH
`define MIDI_NOTE_SINE_OSCILLATOR_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define MNSO_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must hold at every clock edge, reset included
`define MNSO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/mnso_pkg.sv
// ----------------------------------------------------------------------------
// mnso_pkg
// Shared constants and table functions of the MIDI note sine oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package mnso_pkg;

   // Datapath sizes
   localparam int PHASE_BITS       = 32;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SAMPLE_BITS      = 16;
   localparam int ADDR_BITS        = $clog2(SINE_TABLE_DEPTH);
   localparam int AMP_BITS         = SAMPLE_BITS - 1;
   localparam int GAIN_BITS        = 16;
   localparam int GAIN_FRAC        = 14;
   localparam int BASE_BITS        = 32;
   localparam int SEMI_BITS        = 17;
   localparam int SEMI_FRAC        = 16;
   localparam int OCT_BITS         = 4;
   localparam int SEMI_IDX_BITS    = 4;
   localparam int NOTE_BITS        = 7;
   localparam int STATUS_BITS      = 8;
   localparam int CSR_INDEX_BITS   = 1;
   localparam int CSR_DATA_BITS    = 32;
   localparam int SEMIS_PER_OCT    = 12;
   localparam int MAX_OCTAVE       = ((1 << NOTE_BITS) - 1) / SEMIS_PER_OCT;

   // Derived widths
   localparam int PROD_BITS        = SAMPLE_BITS + GAIN_BITS;
   localparam int SUM_BITS         = PROD_BITS + 1;
   localparam int NOTE_PROD_BITS   = BASE_BITS + SEMI_BITS;
   localparam int INC_SHIFTED_BITS = NOTE_PROD_BITS - SEMI_FRAC + MAX_OCTAVE;
   localparam int INC_WIDE_BITS    = (INC_SHIFTED_BITS > PHASE_BITS) ?
                                     INC_SHIFTED_BITS : PHASE_BITS;

   // Codes
   localparam logic                   OP_TICK        = 1'b0;
   localparam logic                   OP_EVENT       = 1'b1;
   localparam logic [STATUS_BITS-1:0] NOTE_ON_STATUS = 8'h90;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN     = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_INC = 1'b1;

   // Register reset values
   localparam logic signed [GAIN_BITS-1:0] GAIN_RESET     = 16'sd16384;
   localparam logic [BASE_BITS-1:0]        BASE_INC_RESET = 32'd731567;

   // Rounding bias for the Q2.14 gain product
   localparam logic signed [SUM_BITS-1:0] ROUND_BIAS = SUM_BITS'(1 << (GAIN_FRAC - 1));

   // Saturation limits of the output sample
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Table build constants (pi in Q30)
   localparam longint unsigned PI_Q30    = 64'd3373259426;
   localparam longint unsigned AMP_VALUE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
   localparam longint unsigned QTR_DIV   = 4 * SINE_TABLE_DEPTH;

   typedef struct packed {
      logic [OCT_BITS-1:0]      octave;
      logic [SEMI_IDX_BITS-1:0] semitone;
   } note_split_type;

   // Semitone ratios in Q16: round(65536 * 2^(k/12))
   function automatic logic [SEMI_BITS-1:0] semitone_q16(input logic [SEMI_IDX_BITS-1:0] k);
      logic [SEMI_BITS-1:0] r;
      unique case (k)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd69433;
         4'd2:    r = 17'd73562;
         4'd3:    r = 17'd77936;
         4'd4:    r = 17'd82570;
         4'd5:    r = 17'd87480;
         4'd6:    r = 17'd92682;
         4'd7:    r = 17'd98193;
         4'd8:    r = 17'd104032;
         4'd9:    r = 17'd110218;
         4'd10:   r = 17'd116772;
         4'd11:   r = 17'd123715;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

   // Split a key number into octave and semitone by threshold compares
   function automatic note_split_type split_note(input logic [NOTE_BITS-1:0] note);
      note_split_type       s;
      logic [NOTE_BITS-1:0] base;
      s.octave = '0;
      for (int k = 1; k <= MAX_OCTAVE; k++) begin
         if (note >= NOTE_BITS'(SEMIS_PER_OCT * k)) s.octave = OCT_BITS'(k);
      end
      base       = NOTE_BITS'(SEMIS_PER_OCT * int'(s.octave));
      s.semitone = SEMI_IDX_BITS'(note - base);
      return s;
   endfunction

   // Q30 sine by Taylor series through x^15, evaluated at elaboration
   function automatic longint sine_q30(input longint unsigned x);
      longint          sum;
      longint unsigned term;
      sum  = longint'(x);
      term = x;
      term = ((((term * x) >> 30) * x) >> 30) / 64'd6;   sum = sum - longint'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd20;  sum = sum + longint'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd42;  sum = sum - longint'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd72;  sum = sum + longint'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd110; sum = sum - longint'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd156; sum = sum + longint'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd210; sum = sum - longint'(term);
      return sum;
   endfunction

   // One quarter-wave entry, sampled at the bin center
   function automatic logic [AMP_BITS-1:0] quarter_wave_entry(input int unsigned i);
      longint unsigned x;
      longint          s;
      longint unsigned u;
      longint unsigned e;
      x = (PI_Q30 * (64'd2 * longint'(i) + 64'd1)) / QTR_DIV;
      s = sine_q30(x);
      u = (s < 0) ? 64'd0 : longint'(s);
      e = (u * AMP_VALUE + (64'd1 << 29)) >> 30;
      return AMP_BITS'(e);
   endfunction

endpackage

`default_nettype wire

FILE: sv/midi_note_sine_oscillator_top.sv
// ----------------------------------------------------------------------------
// midi_note_sine_oscillator_top
// DDS sine oscillator whose pitch follows MIDI note-on events.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock cycle while req_ready is high, ticks
// and events alike. A tick reads the sine of the current phase and advances
// the phase accumulator in the cycle it is accepted; its sample reaches rsp_
// through a stage for the quarter-wave table read and a stage for the gain
// multiply, rounding and saturation. The phase add is the loop that sets the
// rate. A note-on event (status 0x90) loads the phase increment from one
// 32x17 multiply and a shift, in time for a tick in the very next cycle;
// events return no sample. Registers are written on the csr_ channel at any
// time the block is idle: index 0 is gain (Q2.14), index 1 the note 0 step.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_sine_oscillator_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_op,
   input  wire logic [mnso_pkg::STATUS_BITS-1:0]     req_status_byte,
   input  wire logic [mnso_pkg::NOTE_BITS-1:0]       req_note_number,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [mnso_pkg::SAMPLE_BITS-1:0]   rsp_sample,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mnso_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [mnso_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import mnso_pkg::*;

   // State and configuration
   logic [PHASE_BITS-1:0]         phase_ff, phase_in;
   logic [PHASE_BITS-1:0]         increment_ff, increment_in;
   logic signed [GAIN_BITS-1:0]   gain_ff, gain_in;
   logic [BASE_BITS-1:0]          base_inc_ff, base_inc_in;

   // Pipeline
   logic                          s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_BITS-1:0] sine_ff, sine_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;

   logic                          req_accept;
   logic                          tick_accept;
   logic                          note_on;
   logic                          advance;
   logic                          csr_write;

   // Quarter-wave table, built at elaboration
   logic [AMP_BITS-1:0]           quarter_wave_w [SINE_TABLE_DEPTH];

   for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_qw
      localparam logic [AMP_BITS-1:0] ENTRY = quarter_wave_entry(gi);
      assign quarter_wave_w[gi] = ENTRY;
   end

   // Handshakes
   assign advance     = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || advance;
   assign req_accept  = req_valid && req_ready;
   assign tick_accept = req_accept && (req_op == OP_TICK);
   assign note_on     = req_accept && (req_op == OP_EVENT) &&
                        (req_status_byte == NOTE_ON_STATUS);
   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;

   // Phase accumulator
   always_comb begin
      phase_in = phase_ff;
      if (tick_accept) phase_in = phase_ff + increment_ff;
   end

   // Note to increment: base * semitone >> 16, then << octave
   always_comb begin
      note_split_type             split;
      logic [NOTE_PROD_BITS-1:0]  prod;
      logic [INC_WIDE_BITS-1:0]   wide;
      split = split_note(req_note_number);
      prod  = NOTE_PROD_BITS'(base_inc_ff) *
              NOTE_PROD_BITS'(semitone_q16(split.semitone));
      wide  = INC_WIDE_BITS'(prod[NOTE_PROD_BITS-1:SEMI_FRAC]) << split.octave;
      increment_in = increment_ff;
      if (note_on) increment_in = wide[PHASE_BITS-1:0];
   end

   // Configuration writes
   always_comb begin
      gain_in     = gain_ff;
      base_inc_in = base_inc_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN:     gain_in     = csr_data[GAIN_BITS-1:0];
            CSR_BASE_INC: base_inc_in = csr_data[BASE_BITS-1:0];
         endcase
      end
   end

   // Stage 1: quadrant mirror and table read
   always_comb begin
      logic [1:0]             quad;
      logic [ADDR_BITS-1:0]   idx;
      logic [AMP_BITS-1:0]    mag;
      logic signed [SAMPLE_BITS-1:0] pos;
      quad    = phase_ff[PHASE_BITS-1 -: 2];
      idx     = phase_ff[PHASE_BITS-3 -: ADDR_BITS];
      if (quad[0]) idx = ~idx;
      mag     = quarter_wave_w[idx];
      pos     = {1'b0, mag};
      sine_in = quad[1] ? -pos : pos;
   end

   // Stage 2: gain, round half up, saturate
   always_comb begin
      logic signed [PROD_BITS-1:0] prod;
      logic signed [SUM_BITS-1:0]  sum;
      logic signed [SUM_BITS-1:0]  shifted;
      prod    = PROD_BITS'(sine_ff) * PROD_BITS'(gain_ff);
      sum     = SUM_BITS'(prod) + ROUND_BIAS;
      shifted = sum >>> GAIN_FRAC;
      if (shifted > SUM_BITS'(SAMPLE_MAX))      rsp_sample_in = SAMPLE_MAX;
      else if (shifted < SUM_BITS'(SAMPLE_MIN)) rsp_sample_in = SAMPLE_MIN;
      else                                      rsp_sample_in = shifted[SAMPLE_BITS-1:0];
   end

   // Valid flags
   always_comb begin
      s1_valid_in  = advance ? 1'b0 : s1_valid_ff;
      if (tick_accept) s1_valid_in = 1'b1;
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         increment_ff <= '0;
         gain_ff      <= GAIN_RESET;
         base_inc_ff  <= BASE_INC_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         increment_ff <= increment_in;
         gain_ff      <= gain_in;
         base_inc_ff  <= base_inc_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (tick_accept) sine_ff <= sine_in;
      if (advance && s1_valid_ff) rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

`default_nettype wire

FILE: sv/mnso_checker.sv
// ----------------------------------------------------------------------------
// mnso_checker
// Port-level checks of the MIDI note sine oscillator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_note_sine_oscillator_top_assert.svh"

module mnso_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               req_op,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [mnso_pkg::SAMPLE_BITS-1:0] rsp_sample
);
   import mnso_pkg::*;

   // A stalled sample holds until taken
   `MNSO_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample), "rsp sample dropped or changed while stalled")

   // Reset empties the output register
   `MNSO_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // Input only stalls behind a full output register
   `MNSO_ASSERT(a_stall_cause, clock, reset, !req_ready |-> rsp_valid, "req stalled with empty output")

   // A new sample follows an accepted tick
   `MNSO_ASSERT(a_sample_from_tick, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_op == OP_TICK), 2), "sample without a tick")

endmodule

bind midi_note_sine_oscillator_top mnso_checker u_mnso_checker (.*);

`default_nettype wire
